// ----- rtl/core/osstk_pkg.sv -----
package osstk_pkg;

   // Width of the entry count reported with every result.
   localparam int COUNT_W = 9;
   localparam int VALUE_W = 32;

   // Request actions.
   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_PEEK   = 2'd1,
      ACT_POP    = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   // One result beat.
   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] popped;
      logic                      full_res;
      logic [COUNT_W-1:0]        count;
   } result_type;

   // Engine status towards the top level.
   typedef struct packed {
      logic       idle;
      logic       done;
      result_type res;
   } status_type;

endpackage

// ----- rtl/core/osstk_engine.sv -----
module osstk_engine
   import osstk_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_take,
   input  action_type                req_act,
   input  logic signed [VALUE_W-1:0] req_val,
   input  logic                      allow_dup,
   input  logic                      res_take,
   output status_type                status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_FILL = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   action_type                act_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [CW-1:0]             fill_ff;
   logic [CW-1:0]             scan_ff;
   logic                      pend_ff;
   logic [AW-1:0]             pend_idx_ff;
   result_type                res_ff;
   logic [VALUE_W-1:0]        rdata_ff;

   logic [VALUE_W-1:0] mem [CAPACITY];

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               search_hit;
   logic               scan_more;
   logic               is_full;
   logic [CW-1:0]      fill_inc;
   logic [CW-1:0]      fill_dec;

   function automatic result_type make_res(input logic ok, input logic [VALUE_W-1:0] popped,
                                           input logic full_res, input logic [CW-1:0] fill);
      result_type r;
      r.ok       = ok;
      r.popped   = popped;
      r.full_res = full_res;
      r.count    = COUNT_W'(fill);
      return r;
   endfunction

   // Shared decisions of the scan loops.
   assign search_hit = pend_ff && (rdata_ff == val_ff);
   assign scan_more  = scan_ff < fill_ff;
   assign is_full    = fill_ff == CAP_FILL;
   assign fill_inc   = fill_ff + 1'b1;
   assign fill_dec   = fill_ff - 1'b1;

   // Memory port control: one read and one write per cycle.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = fill_ff[AW-1:0];
      wr_data = rdata_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_act == ACT_POP && fill_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = fill_dec[AW-1:0];
            end
            if (req_take && req_act == ACT_ADD && allow_dup && !is_full) begin
               wr_en   = 1'b1;
               wr_data = req_val;
            end
         end
         ST_SEARCH: begin
            if (!search_hit && scan_more) begin
               rd_en = 1'b1;
            end
            if (!search_hit && !scan_more && act_ff == ACT_ADD && !is_full) begin
               wr_en   = 1'b1;
               wr_data = val_ff;
            end
         end
         ST_SHIFT: begin
            // Each entry moves down one place once its read data is back.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - 1'b1;
            end
            if (scan_more) begin
               rd_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Entry storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  act_ff  <= req_act;
                  val_ff  <= req_val;
                  scan_ff <= '0;
                  pend_ff <= 1'b0;
                  case (req_act)
                     ACT_ADD: begin
                        if (!allow_dup) begin
                           state_ff <= ST_SEARCH;
                        end else if (is_full) begin
                           res_ff   <= make_res(1'b0, '0, 1'b1, fill_ff);
                           state_ff <= ST_DONE;
                        end else begin
                           fill_ff  <= fill_inc;
                           res_ff   <= make_res(1'b1, '0, 1'b0, fill_inc);
                           state_ff <= ST_DONE;
                        end
                     end
                     ACT_POP: begin
                        if (fill_ff == '0) begin
                           res_ff   <= make_res(1'b0, '0, 1'b0, fill_ff);
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_POP;
                        end
                     end
                     default: begin
                        state_ff <= ST_SEARCH;
                     end
                  endcase
               end
            end
            ST_POP: begin
               fill_ff  <= fill_dec;
               res_ff   <= make_res(1'b1, rdata_ff, 1'b0, fill_dec);
               state_ff <= ST_DONE;
            end
            ST_SEARCH: begin
               if (search_hit) begin
                  pend_ff <= 1'b0;
                  case (act_ff)
                     ACT_ADD: begin
                        res_ff   <= make_res(1'b0, '0, 1'b0, fill_ff);
                        state_ff <= ST_DONE;
                     end
                     ACT_REMOVE: begin
                        scan_ff  <= CW'(pend_idx_ff) + 1'b1;
                        state_ff <= ST_SHIFT;
                     end
                     default: begin
                        res_ff   <= make_res(1'b1, '0, 1'b0, fill_ff);
                        state_ff <= ST_DONE;
                     end
                  endcase
               end else if (scan_more) begin
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= scan_ff[AW-1:0];
                  scan_ff     <= scan_ff + 1'b1;
               end else begin
                  // Value absent from every stored entry.
                  pend_ff  <= 1'b0;
                  state_ff <= ST_DONE;
                  if (act_ff == ACT_ADD) begin
                     if (is_full) begin
                        res_ff <= make_res(1'b0, '0, 1'b1, fill_ff);
                     end else begin
                        fill_ff <= fill_inc;
                        res_ff  <= make_res(1'b1, '0, 1'b0, fill_inc);
                     end
                  end else begin
                     res_ff <= make_res(1'b0, '0, 1'b0, fill_ff);
                  end
               end
            end
            ST_SHIFT: begin
               if (scan_more) begin
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= scan_ff[AW-1:0];
                  scan_ff     <= scan_ff + 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  fill_ff  <= fill_dec;
                  res_ff   <= make_res(1'b1, '0, 1'b0, fill_dec);
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (res_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.idle = state_ff == ST_IDLE;
   assign status.done = state_ff == ST_DONE;
   assign status.res  = res_ff;

   // The entry count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CAP_FILL)
      else $error("entry count above capacity");

   // A refused full add never reports success as well.
   assert property (@(posedge clock) disable iff (reset)
      status.done |-> !(res_ff.ok && res_ff.full_res))
      else $error("result both ok and full");

   // Only a pop returns a nonzero value.
   assert property (@(posedge clock) disable iff (reset)
      (status.done && res_ff.popped != '0) |-> act_ff == ACT_POP)
      else $error("popped value on a non-pop action");

   // The count moves by one at most, and only as a result is produced.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         (state_ff == ST_DONE &&
          (fill_ff == $past(fill_ff) + 1'b1 || fill_ff == $past(fill_ff) - 1'b1)))
      else $error("entry count changed unexpectedly");

   // A write in the compaction pass never lands on or above the new top.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && wr_en) |-> CW'(wr_addr) < fill_dec)
      else $error("compaction write out of range");

endmodule

// ----- rtl/core/ordered_integer_set_stack.sv -----
// Ordered integer set and stack.
// Requests arrive on the req_ channel (req_valid, req_stall, req_action,
// req_value); each request gives exactly one result beat on the rsp_
// channel (rsp_valid, rsp_stall, rsp_ok, rsp_popped, rsp_full_res,
// rsp_count). A beat moves at a clock edge with valid high and stall low.
// The csr_ channel writes the allow-duplicates flag; it is always ready and
// should only be written while no request is in progress.
// Requests are handled one at a time. Peek and add without duplicates scan
// the entries one per cycle from the entry memory. A remove searches and then
// compacts the entries above the hit through the same memory port.
// The result sits in an output register, so a new request is accepted while
// the previous result is stalled; a second result waits inside the engine,
// which then holds req_stall high until the output register frees up.
// Synchronous reset empties the array and clears the flag; the entry memory
// itself needs no clearing since only entries below the count are read.
module ordered_integer_set_stack
   import osstk_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_ok,
   output logic signed [VALUE_W-1:0] rsp_popped,
   output logic                      rsp_full_res,
   output logic [COUNT_W-1:0]        rsp_count,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_allow_duplicates
);

   logic       allow_dup_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   status_type status;
   logic       req_take;
   logic       res_take;

   assign req_stall = !status.idle;
   assign req_take  = req_valid && !req_stall;
   assign res_take  = status.done && (!rsp_valid_ff || !rsp_stall);

   // Configuration register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_dup_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         allow_dup_ff <= csr_allow_duplicates;
      end
   end

   osstk_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req_act   (action_type'(req_action)),
      .req_val   (req_value),
      .allow_dup (allow_dup_ff),
      .res_take  (res_take),
      .status    (status)
   );

   // Output register for the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= status.res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_data_ff.ok;
   assign rsp_popped   = rsp_data_ff.popped;
   assign rsp_full_res = rsp_data_ff.full_res;
   assign rsp_count    = rsp_data_ff.count;

endmodule

// ----- dv/osstk_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and register channels of the ordered integer
// set and stack, keeps its own copy of the array and checks every result.
module osstk_checker
   import osstk_pkg::*;
#(
   parameter int SET_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_ok,
   input  logic signed [VALUE_W-1:0] rsp_popped,
   input  logic                      rsp_full_res,
   input  logic [COUNT_W-1:0]        rsp_count,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic                      csr_allow_duplicates,
   output int                        fail_count,
   output int                        pending
);

   // Shadow copy of the array, its fill level and the duplicate flag.
   logic signed [VALUE_W-1:0] shadow_entries [SET_DEPTH];
   int                        shadow_fill;
   bit                        shadow_allow_dup;

   // Results owed by the block, oldest first.
   result_type awaited_results [$];

   // Position of the first entry equal to v, or -1 when absent.
   function automatic int locate_value(logic signed [VALUE_W-1:0] v);
      for (int i = 0; i < shadow_fill; i++) begin
         if (shadow_entries[i] == v) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one request to the shadow array and returns the result it gives.
   function automatic result_type apply_request(action_type act,
                                                logic signed [VALUE_W-1:0] v);
      result_type r;
      int         pos;
      r = '0;
      case (act)
         ACT_ADD: begin
            // The duplicate check comes before the capacity check.
            if (!shadow_allow_dup && locate_value(v) >= 0) begin
               r.ok = 1'b0;
            end else if (shadow_fill >= SET_DEPTH) begin
               r.full_res = 1'b1;
            end else begin
               shadow_entries[shadow_fill] = v;
               shadow_fill++;
               r.ok = 1'b1;
            end
         end
         ACT_PEEK: begin
            r.ok = (locate_value(v) >= 0);
         end
         ACT_POP: begin
            if (shadow_fill > 0) begin
               shadow_fill--;
               r.popped = shadow_entries[shadow_fill];
               r.ok     = 1'b1;
            end
         end
         default: begin
            // Remove closes the gap so that the order is kept.
            pos = locate_value(v);
            if (pos >= 0) begin
               for (int i = pos; i + 1 < shadow_fill; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_fill--;
               r.ok = 1'b1;
            end
         end
      endcase
      r.count = COUNT_W'(shadow_fill);
      return r;
   endfunction

   function automatic int report_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      int         errs;
      if (reset) begin
         shadow_fill      = 0;
         shadow_allow_dup = 1'b0;
         awaited_results.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         errs = 0;
         // A result beat is checked against the oldest owed result.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result beat with none expected", $time);
               errs++;
            end else begin
               want = awaited_results.pop_front();
               errs += report_field("ok", want.ok, rsp_ok);
               errs += report_field("popped", want.popped, rsp_popped);
               errs += report_field("full_res", want.full_res, rsp_full_res);
               errs += report_field("count", want.count, rsp_count);
            end
         end
         if (csr_valid && csr_ready) begin
            shadow_allow_dup = csr_allow_duplicates;
         end
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_request(action_type'(req_action), req_value));
         end
         fail_count <= fail_count + errs;
         pending    <= awaited_results.size();
      end
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import osstk_pkg::*;

   localparam int SET_DEPTH   = 256;
   // Longest legal stretch without a beat is a full scan plus the longest
   // sender gap and receiver stall; the limit allows several times that.
   localparam int QUIET_LIMIT = 2000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_action = ACT_PEEK;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_ok;
   logic signed [VALUE_W-1:0] rsp_popped;
   logic                      rsp_full_res;
   logic [COUNT_W-1:0]        rsp_count;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_allow_duplicates = 1'b0;

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   int stall_left   = 0;
   bit calm         = 1'b0;

   ordered_integer_set_stack #(
      .CAPACITY(SET_DEPTH)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ok               (rsp_ok),
      .rsp_popped           (rsp_popped),
      .rsp_full_res         (rsp_full_res),
      .rsp_count            (rsp_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_allow_duplicates (csr_allow_duplicates)
   );

   osstk_checker #(
      .SET_DEPTH(SET_DEPTH)
   ) i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ok               (rsp_ok),
      .rsp_popped           (rsp_popped),
      .rsp_full_res         (rsp_full_res),
      .rsp_count            (rsp_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_allow_duplicates (csr_allow_duplicates),
      .fail_count           (fail_count),
      .pending              (pending)
   );

   always #1 clock = ~clock;

   // Receiver stalls: mostly none or short, now and then long.
   always @(negedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (calm || r < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = (r < 90) ? $urandom_range(0, 2) : $urandom_range(4, 39);
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one request beat, with a random gap in front unless calm.
   // Called and left at a falling edge; valid stays high afterwards.
   task automatic send(action_type act, logic signed [VALUE_W-1:0] v);
      int r;
      int gap;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!calm) begin
         if (r >= 90) begin
            gap = $urandom_range(10, 60);
         end else if (r >= 60) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stops sending and waits for every owed result.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Writes the duplicate flag; only called with the block idle.
   task automatic write_allow_dup(bit v);
      drain();
      csr_valid            <= 1'b1;
      csr_allow_duplicates <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Values: a small pool for hits and duplicates, the extremes, or anything.
   function automatic logic signed [VALUE_W-1:0] pick_value(int pool_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < pool_pct) begin
         return $signed($urandom_range(0, 11)) - 6;
      end else if (r < pool_pct + 8) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return -1;
         endcase
      end
      return $signed($urandom());
   endfunction

   function automatic action_type pick_action(int w_add, int w_peek, int w_pop);
      int r;
      r = $urandom_range(0, 99);
      if (r < w_add) return ACT_ADD;
      if (r < w_add + w_peek) return ACT_PEEK;
      if (r < w_add + w_peek + w_pop) return ACT_POP;
      return ACT_REMOVE;
   endfunction

   // One random phase with a given operation mix and value pool share.
   task automatic run_phase(int items, int w_add, int w_peek, int w_pop, int pool_pct);
      for (int n = 0; n < items; n++) begin
         if (n % 50 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         send(pick_action(w_add, w_peek, w_pop), pick_value(pool_pct));
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty array, extremes, duplicates, remove at the first, a middle and the last position.
      send(ACT_POP, 32'sh1234_5678);
      send(ACT_REMOVE, 5);
      send(ACT_PEEK, 5);
      send(ACT_ADD, 32'sh8000_0000);
      send(ACT_ADD, 32'sh7fff_ffff);
      send(ACT_ADD, 0);
      send(ACT_ADD, -1);
      send(ACT_ADD, -1);
      send(ACT_PEEK, 32'sh7fff_ffff);
      send(ACT_PEEK, -2);
      send(ACT_REMOVE, 32'sh7fff_ffff);
      send(ACT_POP, 0);
      send(ACT_POP, 0);
      send(ACT_ADD, 5);
      send(ACT_ADD, 32'shaaaa_aaaa);
      send(ACT_ADD, 32'sh5555_5555);
      send(ACT_REMOVE, 32'sh8000_0000);
      send(ACT_PEEK, 5);
      send(ACT_REMOVE, 32'sh5555_5555);
      send(ACT_POP, 0);
      send(ACT_POP, 0);
      send(ACT_POP, 0);
      write_allow_dup(1'b1);
      send(ACT_ADD, 7);
      send(ACT_ADD, 7);
      send(ACT_REMOVE, 7);
      send(ACT_POP, 0);

      // Random phases: mixed set use, fill past capacity with duplicates,
      // set use on a full array, then drain as a stack.
      write_allow_dup(1'b0);
      run_phase(350, 40, 20, 15, 50);
      write_allow_dup(1'b1);
      run_phase(400, 85, 5, 5, 30);
      write_allow_dup(1'b0);
      run_phase(300, 50, 20, 10, 40);
      write_allow_dup(1'b1);
      run_phase(400, 10, 10, 60, 40);

      // Let the last results come out, then a margin for stray beats.
      drain();
      repeat (SET_DEPTH + 40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
